// File: rtl/rmf_pkg.sv
`default_nettype none
package rmf_pkg;

   localparam int WINDOW      = 11;
   localparam int SAMPLE_BITS = 16;
   localparam int IN_BITS     = 16;
   localparam int OUT_BITS    = 16;
   localparam int SLOT_BITS   = $clog2(WINDOW);
   localparam int CNT_BITS    = $clog2(WINDOW + 1);

   // one stored sample of the sorted window
   typedef struct packed {
      logic                   valid;
      logic [SAMPLE_BITS-1:0] value;
      logic [SLOT_BITS-1:0]   slot;
   } entry_type;

   // handed from a cell to the cell below it (next smaller rank)
   typedef struct packed {
      logic      removed;  // the oldest entry sits at or above this rank
      logic      ge;       // the compacted entry at this rank is >= the new sample
      entry_type kept;     // compacted entry at this rank
   } link_type;

   // keep the low SAMPLE_BITS of the request; zero is reserved as the stopper
   function automatic logic [SAMPLE_BITS-1:0] fix_sample(input logic [IN_BITS-1:0] s);
      logic [IN_BITS+SAMPLE_BITS-1:0] w;
      logic [SAMPLE_BITS-1:0]         v;
      w = (IN_BITS + SAMPLE_BITS)'(s);
      v = w[SAMPLE_BITS-1:0];
      if (v == '0) begin
         v = SAMPLE_BITS'(1);
      end
      return v;
   endfunction

   function automatic logic [OUT_BITS-1:0] to_median(input logic [SAMPLE_BITS-1:0] v);
      logic [OUT_BITS+SAMPLE_BITS-1:0] w;
      w = (OUT_BITS + SAMPLE_BITS)'(v);
      return w[OUT_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

// File: rtl/rmf_req_if.sv
`default_nettype none
interface rmf_req_if;
   logic                         valid;
   logic                         ready;
   logic [rmf_pkg::IN_BITS-1:0]  sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

// File: rtl/rmf_rsp_if.sv
`default_nettype none
interface rmf_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rmf_pkg::OUT_BITS-1:0] median;

   modport source (output valid, output median, input ready);
   modport sink   (input valid, input median, output ready);
endinterface
`default_nettype wire

// File: rtl/rmf_cell.sv
`default_nettype none
module rmf_cell (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 load,
   input  wire                                 full,
   input  wire  [rmf_pkg::SAMPLE_BITS-1:0]     smp,
   input  wire  [rmf_pkg::SLOT_BITS-1:0]       slot,
   input  rmf_pkg::entry_type                  nxt_entry,
   input  rmf_pkg::link_type                   link_in,
   output rmf_pkg::link_type                   link_out,
   output rmf_pkg::entry_type                  entry
);

   rmf_pkg::entry_type ent_ff;
   rmf_pkg::entry_type ent_in;
   rmf_pkg::entry_type kept;
   rmf_pkg::entry_type fresh;
   logic               rm;
   logic               gone;
   logic               ge;

   always_comb begin
      // drop the oldest entry: ranks below it shift up by one
      rm   = full && ent_ff.valid && (ent_ff.slot == slot);
      gone = link_in.removed | rm;
      kept = gone ? nxt_entry : ent_ff;
      ge   = kept.valid && (kept.value >= smp);

      fresh.valid = 1'b1;
      fresh.value = smp;
      fresh.slot  = slot;

      // insert after every value not smaller than the new sample
      if (ge) begin
         ent_in = kept;
      end else if (link_in.ge) begin
         ent_in = fresh;
      end else begin
         ent_in = link_in.kept;
      end

      link_out.removed = gone;
      link_out.ge      = ge;
      link_out.kept    = kept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff.valid <= 1'b0;
      end else if (load) begin
         ent_ff <= ent_in;
      end
   end

   assign entry = ent_ff;

endmodule
`default_nettype wire

// File: rtl/running_median_filter.sv
// The median of a request is registered and shown on rsp_chan in the cycle after it is accepted.
// Throughput: one request per cycle; the sorted window is a row of cells that all update
//    in the accepting cycle, and a request waits only while a median is held unread.
// Reset (synchronous, active high): empties the window, clears the ring pointer, the
//    fill count and the output valid. No clearing pass is needed.
`default_nettype none
module running_median_filter (
   input wire         clock,
   input wire         reset,
   rmf_req_if.sink    req_chan,
   rmf_rsp_if.source  rsp_chan
);

   localparam int W = rmf_pkg::WINDOW;

   // ring pointer and fill count of the window
   logic [rmf_pkg::SLOT_BITS-1:0] slot_ff;
   logic [rmf_pkg::SLOT_BITS-1:0] slot_in;
   logic [rmf_pkg::CNT_BITS-1:0]  fill_ff;
   logic [rmf_pkg::CNT_BITS-1:0]  fill_in;
   logic [rmf_pkg::CNT_BITS-1:0]  fill_less;
   logic [rmf_pkg::CNT_BITS-1:0]  half;
   // rank of the median inside the sorted row
   logic [rmf_pkg::SLOT_BITS-1:0] med_idx_ff;
   logic [rmf_pkg::SLOT_BITS-1:0] med_idx_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;

   logic                          accept;
   logic                          full;
   logic [rmf_pkg::SAMPLE_BITS-1:0] smp;

   rmf_pkg::link_type  link  [0:W];
   rmf_pkg::entry_type ent   [0:W-1];
   rmf_pkg::entry_type nxt   [0:W-1];

   // take a new request whenever the output register is empty or being drained
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign full           = (fill_ff == rmf_pkg::CNT_BITS'(W));
   assign smp            = rmf_pkg::fix_sample(req_chan.sample);

   // head of the chain: nothing removed above, the new sample may go first
   always_comb begin
      link[0].removed = 1'b0;
      link[0].ge      = 1'b1;
      link[0].kept    = '0;
   end

   // the sorted row: largest value in cell 0, each cell hands its entry upward on removal
   // and downward on insertion
   for (genvar i = 0; i < W; i++) begin : g_cell
      if (i < W - 1) begin : g_mid
         assign nxt[i] = ent[i+1];
      end else begin : g_last
         assign nxt[i] = '0;
      end

      rmf_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .load      (accept),
         .full      (full),
         .smp       (smp),
         .slot      (slot_ff),
         .nxt_entry (nxt[i]),
         .link_in   (link[i]),
         .link_out  (link[i+1]),
         .entry     (ent[i])
      );
   end

   always_comb begin
      // advance the ring pointer, wrap at the window size
      if (slot_ff == rmf_pkg::SLOT_BITS'(W - 1)) begin
         slot_in = '0;
      end else begin
         slot_in = slot_ff + 1'b1;
      end

      // grow the fill count until the window is full
      fill_in   = full ? fill_ff : fill_ff + 1'b1;
      // median rank is (k - 1) / 2 for k samples held after this request
      fill_less = fill_in - 1'b1;
      half      = fill_less >> 1;
      med_idx_in = rmf_pkg::SLOT_BITS'(half);

      // hold the result until taken, load it on every accepted request
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         fill_ff      <= '0;
         med_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            slot_ff    <= slot_in;
            fill_ff    <= fill_in;
            med_idx_ff <= med_idx_in;
         end
      end
   end

   // cells only change on an accepted request, so the selected value holds while stalled
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.median = rmf_pkg::to_median(ent[med_idx_ff].value);

endmodule
`default_nettype wire
